@@ hw/rtl/k2uv_pkg.sv @@
// ----------------------------------------------------------------------------
// k2uv_pkg
// Constants shared by the kelvin to (u, v) locus pipeline: polynomial
// coefficients in units of 1e-16, the temperature range and the data widths.
// ----------------------------------------------------------------------------
package k2uv_pkg;

    // Default fraction widths of the results
    localparam int K2UV_UV_FRAC_BITS    = 24;
    localparam int K2UV_SLOPE_FRAC_BITS = 40;

    // Field widths
    localparam int K2UV_T_W     = 14;
    localparam int K2UV_UV_W    = 24;
    localparam int K2UV_SLOPE_W = 32;
    localparam int K2UV_POLY_W  = 64;
    localparam int K2UV_PROD_W  = 128;

    // Valid temperature range
    localparam logic [K2UV_T_W-1:0] K2UV_T_MIN = 14'd1000;
    localparam logic [K2UV_T_W-1:0] K2UV_T_MAX = 14'd15000;

    // Polynomial slots
    localparam int K2UV_UN = 0;
    localparam int K2UV_UD = 1;
    localparam int K2UV_VN = 2;
    localparam int K2UV_VD = 3;

    // Coefficients of c2*T^2 + c1*T + c0, scaled by 1e16
    localparam logic [63:0] K2UV_C2 [4] = '{
        64'd1286412120, 64'd7081451630, 64'd420481691, 64'd1614560530
    };
    localparam logic [63:0] K2UV_C1 [4] = '{
        64'd1541182540000, 64'd8424202350000, 64'd422806245000, 64'd289741816000
    };
    // The linear term of the v denominator is subtracted
    localparam logic [3:0] K2UV_C1_NEG = 4'b1000;
    localparam logic [63:0] K2UV_C0 [4] = '{
        64'd8601177570000000, 64'd10000000000000000,
        64'd3173987260000000, 64'd10000000000000000
    };

    // Saturation limits
    localparam logic [63:0] K2UV_UV_MAX    = 64'hFF_FFFF;
    localparam logic [63:0] K2UV_SLOPE_POS = 64'h7FFF_FFFF;
    localparam logic [63:0] K2UV_SLOPE_NEG = 64'h8000_0000;

endpackage

@@ hw/rtl/kelvin_to_uv_with_slope.sv @@
// ----------------------------------------------------------------------------
// kelvin_to_uv_with_slope
// Planckian locus (u, v) in CIE 1960 UCS and its slopes per kelvin.
// ----------------------------------------------------------------------------
// Input channel s_axis: one temperature in whole kelvin per item in
// s_axis_tdata[13:0]. Values outside 1000..15000 K are clamped and flagged.
// Output channel m_axis: one result item per input item, in order:
// tdata holds u, v (unsigned, UV_FRAC_BITS fraction bits, 24 bits each)
// and du/dT, dv/dT (signed, SLOPE_FRAC_BITS fraction bits, 32 bits each,
// saturating); tuser carries the clamp flag.
// The pipeline has five polynomial stages, three multiplier stages, two
// for the quotient-rule numerator, one stage per slope quotient bit, one
// rounding stage and the output register.
// Throughput: one item per clock. The whole pipeline advances together;
// when the output register holds an untaken item, s_axis_tready drops and
// every stage holds, so nothing is lost or repeated.
// Reset clears every valid bit but the copies in the ratio delay line; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module kelvin_to_uv_with_slope #(
    parameter int UV_FRAC_BITS    = k2uv_pkg::K2UV_UV_FRAC_BITS,
    parameter int SLOPE_FRAC_BITS = k2uv_pkg::K2UV_SLOPE_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [13:0] temperature_k, [15:14] zero
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // [23:0] u_chroma, [47:24] v_chroma,
                                         // [79:48] du_dk, [111:80] dv_dk
    output logic [0:0]   m_axis_tuser    // [0] out_of_range
);
    import k2uv_pkg::*;

    localparam int DLY  = 5 + SLOPE_FRAC_BITS - UV_FRAC_BITS;
    localparam int RQ_W = UV_FRAC_BITS + 1;
    localparam int SQ_W = SLOPE_FRAC_BITS + 1;
    localparam int DL_W = 2 * RQ_W + 2;

    logic en;

    logic                        poly_valid, poly_flag;
    logic [3:0][K2UV_POLY_W-1:0] poly_n, poly_d;

    logic                   mul_valid;
    logic [K2UV_PROD_W-1:0] a_u, b_u, dd_u, a_v, b_v, dd_v;

    logic                   ad_valid, ad_neg_u, ad_neg_v;
    logic [K2UV_PROD_W-1:0] ad_mag_u, ad_den_u, ad_mag_v, ad_den_v;

    logic            ru_valid, ru_flag;
    logic [RQ_W-1:0] ru_q, rv_q;

    logic            su_valid, su_neg, sv_neg;
    logic [SQ_W-1:0] su_q, sv_q;

    logic [DL_W-1:0] r_dly [DLY];
    logic [DL_W-1:0] dly_out;

    logic         r_out_valid;
    logic [111:0] r_out_data;
    logic         r_out_flag;

    // Clamp u or v to its field
    function automatic logic [K2UV_UV_W-1:0] uv_fmt(input logic [63:0] q);
        logic [K2UV_UV_W-1:0] res;
        res = (q > K2UV_UV_MAX) ? K2UV_UV_MAX[K2UV_UV_W-1:0] : q[K2UV_UV_W-1:0];
        return res;
    endfunction

    // Apply sign and saturate a slope magnitude
    function automatic logic [K2UV_SLOPE_W-1:0] slope_fmt(input logic [63:0] q,
                                                          input logic neg);
        logic [63:0] mag;
        logic [K2UV_SLOPE_W-1:0] res;
        if (neg) begin
            mag = (q > K2UV_SLOPE_NEG) ? K2UV_SLOPE_NEG : q;
            res = K2UV_SLOPE_W'(64'd0 - mag);
        end else begin
            mag = (q > K2UV_SLOPE_POS) ? K2UV_SLOPE_POS : q;
            res = mag[K2UV_SLOPE_W-1:0];
        end
        return res;
    endfunction

    // Global advance: hold everything while the result is not taken
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    k2uv_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_temp  (s_axis_tdata[K2UV_T_W-1:0]),
        .o_valid (poly_valid),
        .o_flag  (poly_flag),
        .o_poly  (poly_n),
        .o_deriv (poly_d)
    );

    // Ratios u = Nu/Du and v = Nv/Dv
    k2uv_div #(.W(K2UV_POLY_W), .Q_BITS(UV_FRAC_BITS), .SIDE_W(1)) u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (poly_valid),
        .i_rem   (poly_n[K2UV_UN]),
        .i_den   (poly_n[K2UV_UD]),
        .i_side  (poly_flag),
        .o_valid (ru_valid),
        .o_quot  (ru_q),
        .o_side  (ru_flag)
    );

    k2uv_div #(.W(K2UV_POLY_W), .Q_BITS(UV_FRAC_BITS), .SIDE_W(1)) u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (poly_valid),
        .i_rem   (poly_n[K2UV_VN]),
        .i_den   (poly_n[K2UV_VD]),
        .i_side  (1'b0),
        .o_valid (),
        .o_quot  (rv_q),
        .o_side  ()
    );

    // Quotient-rule products N'D, N D' and D^2
    k2uv_mul u_mul_au (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (poly_valid),
        .i_a (poly_d[K2UV_UN]), .i_b (poly_n[K2UV_UD]),
        .o_valid (mul_valid), .o_prod (a_u)
    );
    k2uv_mul u_mul_bu (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (poly_valid),
        .i_a (poly_n[K2UV_UN]), .i_b (poly_d[K2UV_UD]),
        .o_valid (), .o_prod (b_u)
    );
    k2uv_mul u_mul_du (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (poly_valid),
        .i_a (poly_n[K2UV_UD]), .i_b (poly_n[K2UV_UD]),
        .o_valid (), .o_prod (dd_u)
    );
    k2uv_mul u_mul_av (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (poly_valid),
        .i_a (poly_d[K2UV_VN]), .i_b (poly_n[K2UV_VD]),
        .o_valid (), .o_prod (a_v)
    );
    k2uv_mul u_mul_bv (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (poly_valid),
        .i_a (poly_n[K2UV_VN]), .i_b (poly_d[K2UV_VD]),
        .o_valid (), .o_prod (b_v)
    );
    k2uv_mul u_mul_dv (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (poly_valid),
        .i_a (poly_n[K2UV_VD]), .i_b (poly_n[K2UV_VD]),
        .o_valid (), .o_prod (dd_v)
    );

    k2uv_adiff u_adiff_u (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (mul_valid),
        .i_a (a_u), .i_b (b_u), .i_den (dd_u),
        .o_valid (ad_valid), .o_neg (ad_neg_u), .o_mag (ad_mag_u), .o_den (ad_den_u)
    );
    k2uv_adiff u_adiff_v (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (mul_valid),
        .i_a (a_v), .i_b (b_v), .i_den (dd_v),
        .o_valid (), .o_neg (ad_neg_v), .o_mag (ad_mag_v), .o_den (ad_den_v)
    );

    // Slope quotients |N'D - ND'| / D^2
    k2uv_div #(.W(K2UV_PROD_W), .Q_BITS(SLOPE_FRAC_BITS), .SIDE_W(1)) u_div_su (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ad_valid),
        .i_rem   (ad_mag_u),
        .i_den   (ad_den_u),
        .i_side  (ad_neg_u),
        .o_valid (su_valid),
        .o_quot  (su_q),
        .o_side  (su_neg)
    );

    k2uv_div #(.W(K2UV_PROD_W), .Q_BITS(SLOPE_FRAC_BITS), .SIDE_W(1)) u_div_sv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ad_valid),
        .i_rem   (ad_mag_v),
        .i_den   (ad_den_v),
        .i_side  (ad_neg_v),
        .o_valid (),
        .o_quot  (sv_q),
        .o_side  (sv_neg)
    );

    // Delay the ratios to line up with the slopes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= {ru_valid, ru_flag, rv_q, ru_q};
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end
    assign dly_out = r_dly[DLY-1];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= su_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {slope_fmt(64'(sv_q), sv_neg),
                           slope_fmt(64'(su_q), su_neg),
                           uv_fmt(64'(dly_out[2*RQ_W-1:RQ_W])),
                           uv_fmt(64'(dly_out[RQ_W-1:0]))};
            r_out_flag <= dly_out[2*RQ_W];
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_flag;

    // Ratio delay line stays aligned with the slope dividers
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        su_valid |-> dly_out[DL_W-1])
        else $error("ratio and slope results out of step");

    // Slope numerator magnitude stays below the squared denominator
    a_mag_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ad_valid |-> (ad_mag_u < ad_den_u) && (ad_mag_v < ad_den_v))
        else $error("slope divider input out of range");

    // Rounded u quotient never exceeds one
    a_u_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ru_valid |-> (!ru_q[RQ_W-1] || (ru_q[RQ_W-2:0] == '0)))
        else $error("u quotient above one");

endmodule

@@ hw/rtl/k2uv_poly.sv @@
// ----------------------------------------------------------------------------
// k2uv_poly
// Clamps the temperature and evaluates the four quadratics by Horner's rule
// and their derivatives, in five register stages.
// ----------------------------------------------------------------------------
module k2uv_poly (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  logic [k2uv_pkg::K2UV_T_W-1:0]               i_temp,
    output logic                                        o_valid,
    output logic                                        o_flag,
    output logic [3:0][k2uv_pkg::K2UV_POLY_W-1:0]       o_poly,
    output logic [3:0][k2uv_pkg::K2UV_POLY_W-1:0]       o_deriv
);
    import k2uv_pkg::*;

    logic [4:0]          r_vld;
    logic [4:0]          r_flag;
    logic [K2UV_T_W-1:0] r_t1, r_t2, r_t3;
    logic [3:0][47:0]    r_p2;
    logic [3:0][47:0]    r_h;
    logic [3:0][63:0]    r_d3, r_d4, r_d5;
    logic [3:0][61:0]    r_m;
    logic [3:0][63:0]    r_n;

    logic [K2UV_T_W-1:0] n_t;
    logic                n_flag;

    // Clamp to the valid range and flag it
    always_comb begin
        n_t    = i_temp;
        n_flag = 1'b0;
        if (i_temp < K2UV_T_MIN) begin
            n_t    = K2UV_T_MIN;
            n_flag = 1'b1;
        end
        if (i_temp > K2UV_T_MAX) begin
            n_t    = K2UV_T_MAX;
            n_flag = 1'b1;
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Horner stages: c2*T, then +c1 and derivative, then *T, then +c0
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flag <= {r_flag[3:0], n_flag};
            r_t1   <= n_t;
            r_t2   <= r_t1;
            r_t3   <= r_t2;
            for (int k = 0; k < 4; k++) begin
                r_p2[k] <= 48'(K2UV_C2[k] * 64'(r_t1));
                if (K2UV_C1_NEG[k]) begin
                    r_h[k]  <= 48'(64'(r_p2[k]) - K2UV_C1[k]);
                    r_d3[k] <= {15'd0, r_p2[k], 1'b0} - K2UV_C1[k];
                end else begin
                    r_h[k]  <= 48'(64'(r_p2[k]) + K2UV_C1[k]);
                    r_d3[k] <= {15'd0, r_p2[k], 1'b0} + K2UV_C1[k];
                end
                r_m[k]  <= 62'(r_h[k]) * 62'(r_t3);
                r_d4[k] <= r_d3[k];
                r_n[k]  <= 64'(r_m[k]) + K2UV_C0[k];
                r_d5[k] <= r_d4[k];
            end
        end
    end

    assign o_valid = r_vld[4];
    assign o_flag  = r_flag[4];
    assign o_poly  = r_n;
    assign o_deriv = r_d5;

endmodule

@@ hw/rtl/k2uv_mul.sv @@
// ----------------------------------------------------------------------------
// k2uv_mul
// 64 x 64 unsigned multiplier in three stages: four 32 x 32 partial
// products, the middle sum, then the full 128-bit product.
// ----------------------------------------------------------------------------
module k2uv_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [k2uv_pkg::K2UV_POLY_W-1:0]    i_a,
    input  logic [k2uv_pkg::K2UV_POLY_W-1:0]    i_b,
    output logic                                o_valid,
    output logic [k2uv_pkg::K2UV_PROD_W-1:0]    o_prod
);
    import k2uv_pkg::*;

    logic [2:0]   r_vld;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [63:0]  r_lo2, r_hi2;
    logic [64:0]  r_mid;
    logic [127:0] r_prod;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // Partial products, middle sum, final sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00  <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
            r_p01  <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
            r_p10  <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
            r_p11  <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
            r_mid  <= 65'(r_p01) + 65'(r_p10);
            r_lo2  <= r_p00;
            r_hi2  <= r_p11;
            r_prod <= {r_hi2, r_lo2} + {31'd0, r_mid, 32'd0};
        end
    end

    assign o_valid = r_vld[2];
    assign o_prod  = r_prod;

endmodule

@@ hw/rtl/k2uv_adiff.sv @@
// ----------------------------------------------------------------------------
// k2uv_adiff
// Quotient-rule numerator: magnitude and sign of a - b in two stages, with
// the denominator square carried alongside.
// ----------------------------------------------------------------------------
module k2uv_adiff (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [k2uv_pkg::K2UV_PROD_W-1:0]    i_a,
    input  logic [k2uv_pkg::K2UV_PROD_W-1:0]    i_b,
    input  logic [k2uv_pkg::K2UV_PROD_W-1:0]    i_den,
    output logic                                o_valid,
    output logic                                o_neg,
    output logic [k2uv_pkg::K2UV_PROD_W-1:0]    o_mag,
    output logic [k2uv_pkg::K2UV_PROD_W-1:0]    o_den
);
    import k2uv_pkg::*;

    logic [1:0]             r_vld;
    logic [K2UV_PROD_W:0]   r_diff;
    logic [K2UV_PROD_W-1:0] r_den1, r_den2, r_mag;
    logic                   r_neg;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    // Subtract, then fold to magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= {1'b0, i_a} - {1'b0, i_b};
            r_den1 <= i_den;
            r_neg  <= r_diff[K2UV_PROD_W];
            r_mag  <= r_diff[K2UV_PROD_W] ? (~r_diff[K2UV_PROD_W-1:0] + 1'b1)
                                          : r_diff[K2UV_PROD_W-1:0];
            r_den2 <= r_den1;
        end
    end

    assign o_valid = r_vld[1];
    assign o_neg   = r_neg;
    assign o_mag   = r_mag;
    assign o_den   = r_den2;

endmodule

@@ hw/rtl/k2uv_div.sv @@
// ----------------------------------------------------------------------------
// k2uv_div
// Pipelined restoring divider for a numerator below the divisor: one
// quotient bit per stage, then a rounding stage (half up).
// ----------------------------------------------------------------------------
module k2uv_div #(
    parameter int W      = 64,
    parameter int Q_BITS = 24,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W-1:0]      i_rem,
    input  logic [W-1:0]      i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_BITS:0]   o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [Q_BITS+1];
    logic [W-1:0]      r_rem  [Q_BITS];
    logic [W-1:0]      r_den  [Q_BITS];
    logic [Q_BITS-1:0] r_q    [Q_BITS];
    logic [SIDE_W-1:0] r_side [Q_BITS+1];
    logic [Q_BITS:0]   r_quot;
    logic [W+1:0]      n_twice;

    for (genvar k = 0; k < Q_BITS; k++) begin : g_step
        logic [W-1:0]      rem_in, den_in;
        logic [Q_BITS-1:0] q_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [W:0]        n_rem2, n_sub;

        if (k == 0) begin : g_first
            assign rem_in  = i_rem;
            assign den_in  = i_den;
            assign q_in    = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        // Shift in a zero, try the subtract
        assign n_rem2 = {rem_in, 1'b0};
        assign n_sub  = n_rem2 - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_sub[W] ? n_rem2[W-1:0] : n_sub[W-1:0];
                r_den[k]  <= den_in;
                r_q[k]    <= {q_in[Q_BITS-2:0], ~n_sub[W]};
                r_side[k] <= side_in;
            end
        end
    end

    // Round up when twice the remainder reaches the divisor
    assign n_twice = {1'b0, r_rem[Q_BITS-1], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[Q_BITS] <= 1'b0;
        end else if (i_en) begin
            r_vld[Q_BITS] <= r_vld[Q_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= {1'b0, r_q[Q_BITS-1]}
                    + (Q_BITS+1)'(n_twice >= {2'b00, r_den[Q_BITS-1]});
            r_side[Q_BITS] <= r_side[Q_BITS-1];
        end
    end

    assign o_valid = r_vld[Q_BITS];
    assign o_quot  = r_quot;
    assign o_side  = r_side[Q_BITS];

endmodule
